>>> design/event_time_course_binner_assert.svh
`ifndef EVENT_TIME_COURSE_BINNER_ASSERT_SVH
`define EVENT_TIME_COURSE_BINNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ETCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ETCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/etcb_pkg.sv
package etcb_pkg;

  typedef enum logic [1:0] {
    MODE_EVENT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // One bin entry as kept in the memory.
  typedef struct packed {
    logic [47:0] open_time;
    logic [39:0] elapsed;
    logic [23:0] openings;
    logic [7:0]  max_level;
  } bin_entry_t;

  localparam logic [7:0]  MaxLevelReset = 8'h9C; // -100
  localparam logic [23:0] SpbReset      = 24'd1000;
  localparam logic [47:0] OpenMax       = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] OpenMin       = 48'h8000_0000_0000;
  localparam logic [39:0] ElapsedMax    = 40'hFF_FFFF_FFFF;
  localparam logic [23:0] OpeningsMax   = 24'hFF_FFFF;

  localparam bin_entry_t EntryReset = '{
    open_time: 48'd0, elapsed: 40'd0, openings: 24'd0, max_level: MaxLevelReset};

endpackage

>>> design/event_time_course_binner.sv
// Event time-course binner.
// Input channel (in_valid_i / in_stall_o) carries one transaction per request:
// a dwell event (mode 0), a read-and-clear of one bin (mode 1) or the start of
// a new run (mode 2). Mode 3 is ignored. Only a read produces a result, which
// leaves on the output channel (out_valid_o / out_stall_i).
// The samples-per-bin register is written through cfg_valid_i / cfg_ready_o;
// the port is always ready, and a value of zero acts as one.
// A dwell event is accepted, then passes the bit-serial restoring division
// of the start sample by the bin size (one quotient bit per cycle), then the
// memory read with the level-times-length product, and last the saturating
// update written back to the bin memory. A read is accepted, then reads the
// memory, then clears the bin and loads the result, a step that waits until
// the output register is free; a new-run request is done when accepted.
// Items are handled one at a time. After reset the block sweeps the bin
// memory, one entry per cycle, and stalls input meanwhile; configuration is
// still taken. The result sits in an output register, so a stalled receiver
// does not stop event processing; only a second read waits until the
// earlier result is taken.
module event_time_course_binner #(
  parameter int NUM_BINS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_samples_per_bin_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] start_point_i,
  input  logic [23:0] dwell_length_i,
  input  logic signed [7:0] level_i,
  input  logic [9:0]  read_bin_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  bin_number_o,
  output logic signed [47:0] open_time_sum_o,
  output logic [39:0] elapsed_sum_o,
  output logic [23:0] openings_o,
  output logic signed [7:0] max_level_o
);
  import etcb_pkg::*;

  localparam int BinW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [31:0] LastBin = 32'(NUM_BINS - 1);

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_RD = 3'd3;
  localparam logic [2:0] S_UPD = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [23:0]       spb_q;
  logic [1:0]        mode_q;
  logic [23:0]       len_q;
  logic signed [7:0] lvl_q;
  logic signed [7:0] prev_q;
  logic [31:0]       dvd_q;
  logic [23:0]       rem_q;
  logic [4:0]        cnt_q;
  logic [BinW-1:0]   addr_q;
  logic [BinW-1:0]   clr_q;
  logic signed [32:0] prod_q;
  bin_entry_t        rdata_q;
  bin_entry_t        mem [NUM_BINS];

  logic              in_acc;
  logic [23:0]       spb_eff;
  logic [24:0]       trial;
  logic              qbit;
  logic [31:0]       quot;
  logic [31:0]       rd_ext;
  logic [BinW-1:0]   rd_idx;
  logic              out_free;
  logic              upd_go;
  logic              mem_we;
  logic [BinW-1:0]   mem_waddr;
  bin_entry_t        mem_wdata;
  bin_entry_t        upd;
  logic signed [48:0] ot_sum;
  logic [40:0]       el_sum;
  logic signed [8:0] step;
  logic [24:0]       op_sum;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign spb_eff     = (spb_q == 24'd0) ? 24'd1 : spb_q;

  // One restoring-division step: the remainder always stays below the divisor.
  assign trial = {rem_q, dvd_q[31]};
  assign qbit  = (trial >= {1'b0, spb_eff});
  assign quot  = {dvd_q[30:0], qbit};

  assign rd_ext = {22'd0, read_bin_i};
  assign rd_idx = (rd_ext > LastBin) ? LastBin[BinW-1:0] : rd_ext[BinW-1:0];

  assign out_free = !out_valid_o || !out_stall_i;
  // A read may only finish once the output register can take its result.
  assign upd_go = (state_q == S_UPD) && ((mode_q != MODE_READ) || out_free);

  // Saturating update of one bin for a dwell event.
  always_comb begin
    upd    = rdata_q;
    ot_sum = 49'($signed(rdata_q.open_time)) + 49'(prod_q);
    el_sum = {1'b0, rdata_q.elapsed} + 41'(len_q);
    step   = 9'(lvl_q) - 9'(prev_q);
    op_sum = {1'b0, rdata_q.openings} + 25'(step[7:0]);
    if (ot_sum[48] != ot_sum[47]) begin
      upd.open_time = ot_sum[48] ? OpenMin : OpenMax;
    end else begin
      upd.open_time = ot_sum[47:0];
    end
    upd.elapsed = el_sum[40] ? ElapsedMax : el_sum[39:0];
    if (step > 9'sd0) begin
      upd.openings = op_sum[24] ? OpeningsMax : op_sum[23:0];
    end
    if (lvl_q > $signed(rdata_q.max_level)) begin
      upd.max_level = lvl_q;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = EntryReset;
    if (state_q == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (upd_go) begin
      mem_we    = 1'b1;
      mem_wdata = (mode_q == MODE_READ) ? EntryReset : upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == S_RD) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR: begin
        if (32'(clr_q) == LastBin) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc && mode_i == MODE_EVENT) begin
          state_d = S_DIV;
        end else if (in_acc && mode_i == MODE_READ) begin
          state_d = S_RD;
        end
      end
      S_DIV: begin
        if (cnt_q == 5'd0) state_d = S_RD;
      end
      S_RD: state_d = S_UPD;
      S_UPD: begin
        if (upd_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      spb_q       <= SpbReset;
      prev_q      <= 8'sd0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        spb_q <= cfg_samples_per_bin_i;
      end
      if (in_acc && mode_i == MODE_RUN) begin
        prev_q <= 8'sd0;
      end else if (upd_go && mode_q == MODE_EVENT) begin
        prev_q <= lvl_q;
      end
      if (upd_go && mode_q == MODE_READ) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_i;
      len_q  <= dwell_length_i;
      lvl_q  <= level_i;
      dvd_q  <= start_point_i;
      rem_q  <= 24'd0;
      cnt_q  <= 5'd31;
      addr_q <= rd_idx;
    end
    if (state_q == S_DIV) begin
      dvd_q <= quot;
      rem_q <= qbit ? 24'(trial - {1'b0, spb_eff}) : trial[23:0];
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        addr_q <= (quot > LastBin) ? LastBin[BinW-1:0] : quot[BinW-1:0];
      end
    end
    if (state_q == S_RD) begin
      prod_q <= 33'(lvl_q) * 33'($signed({1'b0, len_q}));
    end
    if (upd_go && mode_q == MODE_READ) begin
      bin_number_o    <= 10'(32'(addr_q));
      open_time_sum_o <= rdata_q.open_time;
      elapsed_sum_o   <= rdata_q.elapsed;
      openings_o      <= rdata_q.openings;
      max_level_o     <= rdata_q.max_level;
    end
  end

`include "event_time_course_binner_assert.svh"

  `ETCB_ASSERT_NEXT(a_event_divides, clk_i, rst_ni, in_acc && mode_i == MODE_EVENT, state_q == S_DIV, "event did not start division")
  `ETCB_ASSERT_NEXT(a_div_to_read, clk_i, rst_ni, state_q == S_DIV && cnt_q == 5'd0, state_q == S_RD, "division did not end in a memory read")
  `ETCB_ASSERT_NOW(a_result_from_read, clk_i, rst_ni, $rose(out_valid_o), $past(upd_go && mode_q == MODE_READ), "result without a read")

endmodule

>>> tb/etcb_checker.sv
module etcb_checker
  import etcb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [23:0]        cfg_samples_per_bin_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         mode_i,
  input  logic [31:0]        start_point_i,
  input  logic [23:0]        dwell_length_i,
  input  logic signed [7:0]  level_i,
  input  logic [9:0]         read_bin_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [9:0]         bin_number_i,
  input  logic signed [47:0] open_time_sum_i,
  input  logic [39:0]        elapsed_sum_i,
  input  logic [23:0]        openings_i,
  input  logic signed [7:0]  max_level_i,
  output int                 error_count_o,
  output int                 pending_reads_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumBins = 1024;

  typedef struct packed {
    logic [9:0]         bin;
    logic signed [47:0] open_time;
    logic [39:0]        elapsed;
    logic [23:0]        openings;
    logic signed [7:0]  max_level;
  } bin_report_t;

  logic [23:0]        spb;
  logic signed [47:0] open_time_q [NumBins];
  logic [39:0]        elapsed_q   [NumBins];
  logic [23:0]        openings_q  [NumBins];
  logic signed [7:0]  max_level_q [NumBins];
  logic signed [7:0]  prev_level;
  bin_report_t        report_queue[$];

  function automatic void flag(input string what, input bin_report_t exp_r,
                               input bin_report_t got_r);
    if (error_count_o < 10)
      $display("%t mismatch (%s): expected bin %0d open %0d elapsed %0d open# %0d max %0d, got bin %0d open %0d elapsed %0d open# %0d max %0d",
               $realtime, what, exp_r.bin, exp_r.open_time, exp_r.elapsed,
               exp_r.openings, exp_r.max_level, got_r.bin, got_r.open_time,
               got_r.elapsed, got_r.openings, got_r.max_level);
    error_count_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint             prod, ot;
    longint unsigned    el;
    int                 step, opn;
    int unsigned        b, div;
    bin_report_t        got_r, exp_r;
    if (!rst_ni) begin
      spb = SpbReset;
      for (int i = 0; i < NumBins; i++) begin
        open_time_q[i] = '0;
        elapsed_q[i]   = '0;
        openings_q[i]  = '0;
        max_level_q[i] = -8'sd100;
      end
      prev_level = '0;
      report_queue.delete();
      error_count_o = 0;
    end else begin
      // Results are compared first; a read taken this edge cannot also leave.
      if (out_valid_i && !out_stall_i) begin
        got_r = '{bin_number_i, open_time_sum_i, elapsed_sum_i, openings_i, max_level_i};
        if (report_queue.size() == 0) begin
          flag("unexpected result", '0, got_r);
        end else begin
          exp_r = report_queue.pop_front();
          if (got_r != exp_r) flag("field", exp_r, got_r);
        end
      end
      if (cfg_valid_i && cfg_ready_i) spb = cfg_samples_per_bin_i;
      if (in_valid_i && !in_stall_i) begin
        case (mode_e'(mode_i))
          MODE_EVENT: begin
            div = (spb == 0) ? 1 : spb;
            b = start_point_i / div;
            if (b > NumBins - 1) b = NumBins - 1;
            prod = longint'(level_i) * longint'({8'd0, dwell_length_i});
            ot = longint'(open_time_q[b]) + prod;
            if (ot > 64'sh7FFF_FFFF_FFFF) ot = 64'sh7FFF_FFFF_FFFF;
            if (ot < -64'sh8000_0000_0000) ot = -64'sh8000_0000_0000;
            open_time_q[b] = ot[47:0];
            el = elapsed_q[b] + dwell_length_i;
            if (el > ElapsedMax) el = ElapsedMax;
            elapsed_q[b] = el[39:0];
            step = int'(level_i) - int'(prev_level);
            if (step > 0) begin
              opn = int'(openings_q[b]) + step;
              if (opn > int'(OpeningsMax)) opn = int'(OpeningsMax);
              openings_q[b] = opn[23:0];
            end
            if (level_i > max_level_q[b]) max_level_q[b] = level_i;
            prev_level = level_i;
          end
          MODE_READ: begin
            b = read_bin_i;
            if (b > NumBins - 1) b = NumBins - 1;
            report_queue.push_back('{b[9:0], open_time_q[b], elapsed_q[b],
                                     openings_q[b], max_level_q[b]});
            open_time_q[b] = '0;
            elapsed_q[b]   = '0;
            openings_q[b]  = '0;
            max_level_q[b] = -8'sd100;
          end
          MODE_RUN: prev_level = '0;
          default: ;
        endcase
      end
    end
    pending_reads_o = report_queue.size();
  end

endmodule

>>> tb/event_time_course_binner_tb.sv
module event_time_course_binner_tb;
  import etcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is slowest on a dwell event; this covers it with margin.
  localparam int DrainCycles = 60;
  // Longest legal silence is the memory sweep after reset plus one event.
  localparam int QuietLimit  = 6000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [23:0]        cfg_samples_per_bin_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = MODE_NONE;
  logic [31:0]        start_point_i = '0;
  logic [23:0]        dwell_length_i = '0;
  logic signed [7:0]  level_i = '0;
  logic [9:0]         read_bin_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [9:0]         bin_number_o;
  logic signed [47:0] open_time_sum_o;
  logic [39:0]        elapsed_sum_o;
  logic [23:0]        openings_o;
  logic signed [7:0]  max_level_o;

  int error_count;
  int pending_reads;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int unsigned bin_size = 1000;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  event_time_course_binner u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_samples_per_bin_i,
    .in_valid_i, .in_stall_o, .mode_i, .start_point_i, .dwell_length_i,
    .level_i, .read_bin_i, .out_valid_o, .out_stall_i, .bin_number_o,
    .open_time_sum_o, .elapsed_sum_o, .openings_o, .max_level_o
  );

  etcb_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_samples_per_bin_i,
    .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .start_point_i, .dwell_length_i,
    .level_i, .read_bin_i, .out_valid_i(out_valid_o), .out_stall_i,
    .bin_number_i(bin_number_o), .open_time_sum_i(open_time_sum_o),
    .elapsed_sum_i(elapsed_sum_o), .openings_i(openings_o), .max_level_i(max_level_o),
    .error_count_o(error_count), .pending_reads_o(pending_reads)
  );

  // The receiver stalls at random, at a rate set by the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("event_time_course_binner_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request and holds it until a transaction takes place. The
  // stall is sampled at the falling edge, where it has settled for the
  // coming rising edge.
  task automatic send(input mode_e mode, input logic [31:0] start,
                      input logic [23:0] len, input logic signed [7:0] lvl,
                      input logic [9:0] rbin);
    logic go;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    start_point_i  <= start;
    dwell_length_i <= len;
    level_i        <= lvl;
    read_bin_i     <= rbin;
    do begin
      @(negedge clk_i);
      go = !in_stall_o;
      @(posedge clk_i);
    end while (!go);
  endtask

  // Bin size is changed only with the block idle: all reads answered and
  // enough cycles for a last event, which answers nothing, to retire.
  task automatic set_bin_size(input logic [23:0] value);
    logic go;
    in_valid_i <= 1'b0;
    while (pending_reads != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_samples_per_bin_i <= value;
    do begin
      @(negedge clk_i);
      go = cfg_ready_o;
      @(posedge clk_i);
    end while (!go);
    cfg_valid_i <= 1'b0;
    bin_size = (value == 0) ? 1 : value;
  endtask

  // Favor the edge bins so reads usually find accumulated data.
  function automatic int unsigned pick_bin();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return $urandom_range(7);
    if (r < 6) return $urandom_range(1023, 1016);
    return $urandom_range(1023);
  endfunction

  task automatic random_request();
    int unsigned   r;
    longint unsigned s;
    logic [23:0]   len;
    logic [7:0]    lvl;
    r = $urandom_range(99);
    if (r < 60) begin
      s = longint'(pick_bin()) * bin_size + $urandom_range(bin_size - 1);
      if ($urandom_range(9) == 0 || s > 64'hFFFF_FFFF) s = $urandom;
      len = ($urandom_range(1) != 0) ? 24'($urandom_range(5000)) : 24'($urandom);
      // Small levels give realistic open/close steps; the rest spans the field.
      lvl = ($urandom_range(1) != 0) ? 8'($urandom_range(6)) : 8'($urandom);
      send(MODE_EVENT, s[31:0], len, lvl, 10'($urandom));
    end else if (r < 85) begin
      send(MODE_READ, $urandom, 24'($urandom), 8'($urandom),
           ($urandom_range(3) == 0) ? 10'($urandom) : 10'(pick_bin()));
    end else if (r < 93) begin
      send(MODE_RUN, $urandom, 24'($urandom), 8'($urandom), 10'($urandom));
    end else begin
      send(MODE_NONE, $urandom, 24'($urandom), 8'($urandom), 10'($urandom));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) random_request();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset bin size: field extremes, the clamp to
    // the last bin, a new run, the unused mode and read-after-clear.
    send(MODE_EVENT, 32'd0, 24'hFF_FFFF, 8'sd127, 10'd0);
    send(MODE_EVENT, 32'd5, 24'd1, -8'sd128, 10'd0);
    send(MODE_EVENT, 32'hFFFF_FFFF, 24'd5, 8'sd3, 10'd0);
    send(MODE_RUN, 32'd0, 24'd0, 8'sd0, 10'd0);
    send(MODE_EVENT, 32'd999, 24'd0, 8'sd5, 10'd0);
    send(MODE_NONE, 32'hFFFF_FFFF, 24'hFF_FFFF, -8'sd1, 10'h3FF);
    send(MODE_READ, 32'd0, 24'd0, 8'sd0, 10'd0);
    send(MODE_READ, 32'd0, 24'd0, 8'sd0, 10'h3FF);
    send(MODE_READ, 32'd0, 24'd0, 8'sd0, 10'd0);
    send(MODE_READ, 32'd0, 24'd0, 8'sd0, 10'd500);

    // A zero bin size acts as one sample per bin.
    set_bin_size(24'd0);
    send(MODE_EVENT, 32'd3, 24'd100, 8'sd2, 10'd0);
    send(MODE_EVENT, 32'd3, 24'd7, -8'sd4, 10'd0);
    send(MODE_READ, 32'd0, 24'd0, 8'sd0, 10'd3);

    // Largest bin size: the top start sample lands in bin 256.
    set_bin_size(24'hFF_FFFF);
    send(MODE_EVENT, 32'hFFFF_FFFF, 24'd9, 8'sd1, 10'd0);
    send(MODE_READ, 32'd0, 24'd0, 8'sd0, 10'd255);

    set_bin_size(24'd1);
    run_phase(8, 53, 180);
    set_bin_size(24'($urandom_range(5000, 2)));
    run_phase(53, 8, 180);
    set_bin_size(24'hFF_FFFF);
    run_phase(0, 0, 180);

    in_valid_i <= 1'b0;
    while (pending_reads != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && pending_reads == 0) begin
      $display("event_time_course_binner_tb: clean");
    end else begin
      $display("event_time_course_binner_tb: errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/etcb_pkg.sv
design/event_time_course_binner.sv
tb/etcb_checker.sv
tb/event_time_course_binner_tb.sv
